FILE: sv/utdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utdc_pkg
// Shared types and constants of the transmit coalescing ring.
// ----------------------------------------------------------------------------
package utdc_pkg;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_TICK  = 2'd1,
      FUNC_DONE  = 2'd2,
      FUNC_FETCH = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_BURST   = 2'd1,
      KIND_DRAINED = 2'd2,
      KIND_FETCH   = 2'd3
   } kind_type;

   // ring size; burst and fetch fields are sized for it
   localparam int          RING_DEPTH          = 128;

   localparam int          CSR_IDX_W           = 2;
   localparam int          CSR_DATA_W          = 8;
   localparam logic [1:0]  CSR_FLUSH_THRESHOLD = 2'd0;
   localparam logic [1:0]  CSR_IDLE_TIMEOUT    = 2'd1;
   localparam logic [1:0]  CSR_RETRY_TIMEOUT   = 2'd2;

   localparam logic [7:0]  THRESHOLD_RESET     = 8'd64;
   localparam logic [7:0]  IDLE_RESET          = 8'd2;
   localparam logic [7:0]  RETRY_RESET         = 8'd3;

   localparam int          FETCH_IDX_W         = 7;
   localparam int          FETCH_SPAN          = 1 << FETCH_IDX_W;

   // result queue between front and back
   localparam int          Q_DEPTH             = 4;
   localparam int          Q_PTR_W             = 2;
   localparam int          Q_CNT_W             = 3;

   // one queue entry holds every result of one word; two marks an ack
   // that is followed by a burst
   typedef struct packed {
      kind_type    kind;
      logic        accepted;
      logic [6:0]  burst_start;
      logic [7:0]  burst_length;
      logic [7:0]  fetch_byte;
      logic        two;
   } entry_type;

   typedef struct packed {
      logic        valid;
      entry_type   entry;
   } push_type;

   typedef struct packed {
      logic [Q_CNT_W-1:0] count;
   } back_status_type;

endpackage

FILE: sv/utdc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utdc_front
// Accepts words, updates ring and flush state, stores bytes and issues
// at most one result entry per word into the result queue.
// ----------------------------------------------------------------------------
module utdc_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             take,
   input  logic [1:0]                       func,
   input  logic [7:0]                       byte_value,
   input  logic                             last_of_write,
   input  logic [utdc_pkg::FETCH_IDX_W-1:0] fetch_index,
   input  logic                             csr_write,
   input  logic [utdc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [utdc_pkg::CSR_DATA_W-1:0]  csr_data,
   output utdc_pkg::push_type               push
);

   localparam int RING_DEPTH = utdc_pkg::RING_DEPTH;
   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int MW = (CW > 8) ? CW : 8;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] pend_ff, pend_in;
   logic          busy_ff, busy_in;
   logic          wrap_ff, wrap_in;
   logic [CW-1:0] wlen_ff, wlen_in;
   logic          armed_ff, armed_in;
   logic [7:0]    ticks_ff, ticks_in;
   logic [7:0]    thr_ff, idle_ff, retry_ff;

   logic [7:0]    ring_mem [RING_DEPTH];
   logic [7:0]    rdata_ff;
   logic          s1_valid_ff;
   utdc_pkg::entry_type s1_entry_ff;

   logic [AW-1:0] fidx_tab [utdc_pkg::FETCH_SPAN];

   // fetch index folded into the ring
   for (genvar g = 0; g < utdc_pkg::FETCH_SPAN; g++) begin : g_fold
      assign fidx_tab[g] = AW'(g % RING_DEPTH);
   end

   logic [SW-1:0] wsum;
   logic [AW-1:0] widx;
   logic          can_store;

   assign wsum      = SW'(head_ff) + SW'(pend_ff);
   assign widx      = (wsum >= SW'(RING_DEPTH)) ? AW'(wsum - SW'(RING_DEPTH)) : AW'(wsum);
   assign can_store = pend_ff < CW'(RING_DEPTH);

   // per-word decode
   logic          mem_we;
   logic          do_flush;
   logic          produce;
   logic [CW-1:0] mid_pend;
   logic          mid_busy;
   logic          base_armed;
   logic [7:0]    base_ticks;
   utdc_pkg::entry_type base_entry;

   always_comb begin
      mem_we     = 1'b0;
      do_flush   = 1'b0;
      produce    = 1'b0;
      mid_pend   = pend_ff;
      mid_busy   = busy_ff;
      base_armed = armed_ff;
      base_ticks = ticks_ff;
      base_entry = '0;
      unique case (utdc_pkg::func_type'(func))
         utdc_pkg::FUNC_WRITE: begin
            base_armed      = 1'b0;
            base_ticks      = 8'd0;
            produce         = 1'b1;
            base_entry.kind = utdc_pkg::KIND_ACK;
            if (can_store) begin
               mem_we              = take;
               mid_pend            = pend_ff + CW'(1);
               base_entry.accepted = 1'b1;
            end
            if (last_of_write) begin
               if (MW'(mid_pend) > MW'(thr_ff)) begin
                  do_flush = 1'b1;
               end else begin
                  base_armed = 1'b1;
                  base_ticks = idle_ff;
               end
            end
         end
         utdc_pkg::FUNC_TICK: begin
            if (armed_ff) begin
               if (ticks_ff <= 8'd1) begin
                  do_flush = 1'b1;
               end else begin
                  base_ticks = ticks_ff - 8'd1;
               end
            end
         end
         utdc_pkg::FUNC_DONE: begin
            mid_busy = 1'b0;
            if (wrap_ff) begin
               do_flush = 1'b1;
            end else begin
               produce         = 1'b1;
               base_entry.kind = utdc_pkg::KIND_DRAINED;
            end
         end
         utdc_pkg::FUNC_FETCH: begin
            produce         = 1'b1;
            base_entry.kind = utdc_pkg::KIND_FETCH;
         end
      endcase
   end

   // flush engine, works on the state left by the decode above
   logic          fl_armed;
   logic [7:0]    fl_ticks;
   logic          fl_busy;
   logic          fl_wrap;
   logic [CW-1:0] fl_wlen;
   logic [AW-1:0] fl_head;
   logic [CW-1:0] fl_pend;
   logic          fl_burst;
   logic [AW-1:0] fl_start;
   logic [CW-1:0] fl_len;
   logic [SW-1:0] fsum;
   logic [CW-1:0] to_top;

   assign fsum   = SW'(head_ff) + SW'(mid_pend);
   assign to_top = CW'(SW'(RING_DEPTH) - SW'(head_ff));

   always_comb begin
      fl_armed = 1'b0;
      fl_ticks = 8'd0;
      fl_busy  = mid_busy;
      fl_wrap  = wrap_ff;
      fl_wlen  = wlen_ff;
      fl_head  = head_ff;
      fl_pend  = mid_pend;
      fl_burst = 1'b0;
      fl_start = '0;
      fl_len   = '0;
      priority if (mid_busy) begin
         fl_armed = 1'b1;
         fl_ticks = retry_ff;
      end else if (wrap_ff) begin
         // second half of a wrapped run starts at index 0
         fl_busy  = 1'b1;
         fl_wrap  = 1'b0;
         fl_burst = 1'b1;
         fl_len   = wlen_ff;
      end else if (mid_pend != '0) begin
         fl_burst = 1'b1;
         fl_busy  = 1'b1;
         fl_pend  = '0;
         fl_start = head_ff;
         if (fsum > SW'(RING_DEPTH)) begin
            fl_len  = to_top;
            fl_wrap = 1'b1;
            fl_wlen = mid_pend - to_top;
         end else begin
            fl_len = mid_pend;
         end
         fl_head = (fsum >= SW'(RING_DEPTH)) ? AW'(fsum - SW'(RING_DEPTH)) : AW'(fsum);
      end else begin
         fl_burst = 1'b0;
      end
   end

   // merge
   logic                produce_all;
   utdc_pkg::entry_type entry;

   always_comb begin
      armed_in    = base_armed;
      ticks_in    = base_ticks;
      busy_in     = mid_busy;
      wrap_in     = wrap_ff;
      wlen_in     = wlen_ff;
      head_in     = head_ff;
      pend_in     = mid_pend;
      produce_all = produce;
      entry       = base_entry;
      if (do_flush) begin
         armed_in           = fl_armed;
         ticks_in           = fl_ticks;
         busy_in            = fl_busy;
         wrap_in            = fl_wrap;
         wlen_in            = fl_wlen;
         head_in            = fl_head;
         pend_in            = fl_pend;
         entry.burst_start  = 7'(fl_start);
         entry.burst_length = 8'(fl_len);
         if (utdc_pkg::func_type'(func) == utdc_pkg::FUNC_WRITE) begin
            entry.two = fl_burst;
         end else begin
            produce_all = fl_burst;
            entry.kind  = utdc_pkg::KIND_BURST;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         pend_ff     <= '0;
         busy_ff     <= 1'b0;
         wrap_ff     <= 1'b0;
         wlen_ff     <= '0;
         armed_ff    <= 1'b0;
         ticks_ff    <= 8'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= take && produce_all;
         if (take) begin
            head_ff  <= head_in;
            pend_ff  <= pend_in;
            busy_ff  <= busy_in;
            wrap_ff  <= wrap_in;
            wlen_ff  <= wlen_in;
            armed_ff <= armed_in;
            ticks_ff <= ticks_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= utdc_pkg::THRESHOLD_RESET;
         idle_ff  <= utdc_pkg::IDLE_RESET;
         retry_ff <= utdc_pkg::RETRY_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            utdc_pkg::CSR_FLUSH_THRESHOLD: thr_ff   <= csr_data;
            utdc_pkg::CSR_IDLE_TIMEOUT:    idle_ff  <= csr_data;
            utdc_pkg::CSR_RETRY_TIMEOUT:   retry_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      s1_entry_ff <= entry;
      if (mem_we) begin
         ring_mem[widx] <= byte_value;
      end
      rdata_ff <= ring_mem[fidx_tab[fetch_index]];
   end

   always_comb begin
      push.valid = s1_valid_ff;
      push.entry = s1_entry_ff;
      push.entry.fetch_byte =
         (s1_entry_ff.kind == utdc_pkg::KIND_FETCH) ? rdata_ff : 8'd0;
   end

endmodule

FILE: sv/utdc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utdc_back
// Result queue and output sequencer: unpacks each entry into one or two
// result words on the response channel.
// ----------------------------------------------------------------------------
module utdc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  utdc_pkg::push_type         push,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_kind,
   output logic                       rsp_accepted,
   output logic [6:0]                 rsp_burst_start,
   output logic [7:0]                 rsp_burst_length,
   output logic [7:0]                 rsp_fetch_byte,
   output logic                       rsp_last,
   output utdc_pkg::back_status_type  status
);

   utdc_pkg::entry_type q_mem [utdc_pkg::Q_DEPTH];
   logic [utdc_pkg::Q_PTR_W-1:0] wp_ff, rp_ff;
   logic [utdc_pkg::Q_CNT_W-1:0] count_ff, count_in;
   logic                         phase_ff;

   utdc_pkg::entry_type head;
   logic                fire;
   logic                pop;
   logic                is_burst;

   assign head      = q_mem[rp_ff];
   assign rsp_valid = count_ff != '0;
   assign fire      = rsp_valid && !rsp_stall;
   assign pop       = fire && (phase_ff || !head.two);
   assign is_burst  = head.kind == utdc_pkg::KIND_BURST;
   assign count_in  = count_ff + utdc_pkg::Q_CNT_W'(push.valid)
                               - utdc_pkg::Q_CNT_W'(pop);

   always_comb begin
      if (phase_ff) begin
         rsp_kind         = utdc_pkg::KIND_BURST;
         rsp_accepted     = 1'b0;
         rsp_burst_start  = head.burst_start;
         rsp_burst_length = head.burst_length;
         rsp_fetch_byte   = 8'd0;
         rsp_last         = 1'b1;
      end else begin
         rsp_kind         = head.kind;
         rsp_accepted     = head.accepted;
         rsp_burst_start  = is_burst ? head.burst_start : 7'd0;
         rsp_burst_length = is_burst ? head.burst_length : 8'd0;
         rsp_fetch_byte   = head.fetch_byte;
         rsp_last         = !head.two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push.valid) begin
            wp_ff <= wp_ff + utdc_pkg::Q_PTR_W'(1);
         end
         if (pop) begin
            rp_ff    <= rp_ff + utdc_pkg::Q_PTR_W'(1);
            phase_ff <= 1'b0;
         end else if (fire) begin
            phase_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         q_mem[wp_ff] <= push.entry;
      end
   end

   assign status.count = count_ff;

endmodule

FILE: sv/uart_tx_dma_coalescing_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_tx_dma_coalescing_buffer
// Transmit byte ring that coalesces writes into DMA bursts.
// ----------------------------------------------------------------------------
// A request's first result word passes the front stage register (with
// the registered ring read) and then the result queue. Throughput: one
// request per cycle while req_stall is low; a write that flushes at once yields
// two result words, so the response port then sets the pace. Queue: 4 entries.
// Reset: synchronous; state and queue cleared, config back to defaults,
// requests stalled, ring contents are kept and not swept.
module uart_tx_dma_coalescing_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_byte_value,
   input  logic        req_last_of_write,
   input  logic [6:0]  req_fetch_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic        rsp_accepted,
   output logic [6:0]  rsp_burst_start,
   output logic [7:0]  rsp_burst_length,
   output logic [7:0]  rsp_fetch_byte,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   utdc_pkg::push_type        push;
   utdc_pkg::back_status_type status;
   logic                      take;

   // room for the entry in the front stage plus the new word
   assign req_stall = reset ||
                      ((status.count + utdc_pkg::Q_CNT_W'(push.valid))
                       >= utdc_pkg::Q_CNT_W'(utdc_pkg::Q_DEPTH));
   assign take      = req_valid && !req_stall;

   utdc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .func          (req_func),
      .byte_value    (req_byte_value),
      .last_of_write (req_last_of_write),
      .fetch_index   (req_fetch_index),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .push          (push)
   );

   utdc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_accepted     (rsp_accepted),
      .rsp_burst_start  (rsp_burst_start),
      .rsp_burst_length (rsp_burst_length),
      .rsp_fetch_byte   (rsp_fetch_byte),
      .rsp_last         (rsp_last),
      .status           (status)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> status.count < utdc_pkg::Q_CNT_W'(utdc_pkg::Q_DEPTH))
      else $error("result queue overflow");

   a_burst_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last)
      |=> (rsp_valid && rsp_kind == utdc_pkg::KIND_BURST))
      else $error("ack with follow-on burst not followed by burst");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule
